[rtl/mcv_pkg.sv]
// types, constants and mask tables shared by the 3x3 mask convolution unit
// no dependencies; every other file in rtl except mcv_ram refers to this package by scoped names
`default_nettype none

package mcv_pkg;

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 10;
    localparam int SUM_W  = 14;
    localparam int HGT_W  = 13;
    localparam int WID_W  = 11;
    localparam int SEL_W  = 3;
    localparam int RECIP_W = 14;
    localparam int RECIP_SHIFT = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MASK_SELECT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT_PIXELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd3;

    localparam logic [WID_W-1:0] IMAGE_WIDTH_RESET  = 11'd512;
    localparam logic [HGT_W-1:0] IMAGE_HEIGHT_RESET = 13'd512;
    localparam logic [HGT_W-1:0] HEIGHT_MIN = 13'd3;
    localparam logic [HGT_W-1:0] HEIGHT_MAX = 13'd4096;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [4:0]        coef_t;
    typedef logic [RECIP_W-1:0]       recip_t;

    localparam sum_t CLAMP_MAX_8 = 14'sd255;
    localparam sum_t CLAMP_MAX_4 = 14'sd16;

    // taps in raster order: top row, middle row, bottom row
    localparam coef_t MASK_COEF [8][9] = '{
        '{ 5'sd0,  5'sd1,  5'sd0,  5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd2,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
        '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{ 5'sd1, -5'sd2,  5'sd1, -5'sd2,  5'sd5, -5'sd2,  5'sd1, -5'sd2,  5'sd1},
        '{ 5'sd0,  5'sd1,  5'sd0,  5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd1,  5'sd0}
    };

    // ceil(2^16 / divisor) for the lowpass masks; exact for sums up to 4080
    localparam recip_t MASK_RECIP [8] = '{
        14'd10923, 14'd7282, 14'd6554, 14'd4096, 14'd0, 14'd0, 14'd0, 14'd10923
    };

    // lowpass selectors (including the unused code that aliases mask 0)
    localparam logic [7:0] MASK_LOWPASS = 8'b1000_1111;

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
    } in_item_t;

    typedef struct packed {
        pix_t filtered_value;
        row_t centre_row;
        col_t centre_col;
        logic frame_last;
    } out_item_t;

    typedef struct packed {
        logic [SEL_W-1:0] mask_select;
        logic             four_bit_pixels;
        logic [WID_W-1:0] image_width;
        logic [HGT_W-1:0] image_height;
    } cfg_t;

    // one complete window handed from the front to the back
    typedef struct packed {
        pix_t [8:0] win;
        row_t       centre_row;
        col_t       centre_col;
        logic       frame_last;
    } task_t;

endpackage

`default_nettype wire

[rtl/mcv_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module mcv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/mcv_front.sv]
// front end: pixel position tracking, line store access and window assembly
// depends on mcv_pkg and mcv_ram
`default_nettype none

module mcv_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mcv_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    input  wire mcv_pkg::in_item_t             in_data,
    output logic                               in_stall,
    input  wire logic [mcv_pkg::QCNT_W-1:0]    q_count,
    output logic                               push,
    output mcv_pkg::task_t                     push_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = ($clog2(MAX_WIDTH + 1) > mcv_pkg::WID_W) ?
                        $clog2(MAX_WIDTH + 1) : mcv_pkg::WID_W;
    localparam logic [EW-1:0] W_MIN = EW'(3);
    localparam logic [EW-1:0] W_MAX = EW'(MAX_WIDTH);
    localparam int LW = 2 * mcv_pkg::PIX_W;

    // effective geometry
    logic [EW-1:0]              iw;
    logic [EW-1:0]              w_eff;
    logic [mcv_pkg::HGT_W-1:0]  h_eff;

    // position of the incoming pixel
    logic [CW-1:0]              col_count_reg;
    logic [CW-1:0]              col_count_next;
    mcv_pkg::row_t              row_count_reg;
    mcv_pkg::row_t              row_count_next;
    logic                       col_over;
    logic [mcv_pkg::HGT_W-1:0]  row_pre;
    logic [CW-1:0]              cur_col;
    mcv_pkg::row_t              cur_row;
    logic [EW-1:0]              col_inc;
    logic [mcv_pkg::HGT_W-1:0]  row_inc;
    logic                       cur_prod;
    logic                       cur_last;
    logic [CW-1:0]              cur_col_m1;
    logic                       accept;

    // stage after acceptance
    logic                       s1_valid_reg;
    mcv_pkg::pix_t              s1_px_reg;
    logic [CW-1:0]              s1_col_reg;
    logic                       s1_prod_reg;
    mcv_pkg::row_t              s1_crow_reg;
    mcv_pkg::col_t              s1_ccol_reg;
    logic                       s1_last_reg;
    logic                       fwd_hit_reg;
    logic [LW-1:0]              fwd_data_reg;

    logic [LW-1:0]              ram_rdata;
    logic [LW-1:0]              line;
    mcv_pkg::pix_t              line_top;
    mcv_pkg::pix_t              line_mid;
    mcv_pkg::pix_t              win_reg [6];
    logic [mcv_pkg::QCNT_W-1:0] pending;

    always_comb
    begin
        iw = EW'(cfg.image_width);
        if (iw < W_MIN)
        begin
            w_eff = W_MIN;
        end
        else if (iw > W_MAX)
        begin
            w_eff = W_MAX;
        end
        else
        begin
            w_eff = iw;
        end

        if (cfg.image_height < mcv_pkg::HEIGHT_MIN)
        begin
            h_eff = mcv_pkg::HEIGHT_MIN;
        end
        else if (cfg.image_height > mcv_pkg::HEIGHT_MAX)
        begin
            h_eff = mcv_pkg::HEIGHT_MAX;
        end
        else
        begin
            h_eff = cfg.image_height;
        end
    end

    // position of this pixel, including wrap after a geometry change
    always_comb
    begin
        col_over = (EW'(col_count_reg) >= w_eff);
        row_pre  = col_over ? ({1'b0, row_count_reg} + 13'd1) : {1'b0, row_count_reg};
        if (in_data.frame_start)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else
        begin
            cur_col = col_over ? '0 : col_count_reg;
            cur_row = (row_pre >= h_eff) ? '0 : mcv_pkg::row_t'(row_pre);
        end

        col_inc = EW'(cur_col) + EW'(1);
        row_inc = {1'b0, cur_row} + 13'd1;
        if (col_inc >= w_eff)
        begin
            col_count_next = '0;
            row_count_next = (row_inc >= h_eff) ? '0 : mcv_pkg::row_t'(row_inc);
        end
        else
        begin
            col_count_next = CW'(col_inc);
            row_count_next = cur_row;
        end

        cur_prod   = (cur_row >= mcv_pkg::row_t'(2)) && (cur_col >= CW'(2));
        cur_last   = ({1'b0, cur_row} == (h_eff - 13'd1)) &&
                     (EW'(cur_col) == (w_eff - EW'(1)));
        cur_col_m1 = cur_col - CW'(1);
    end

    assign pending  = q_count + mcv_pkg::QCNT_W'(push);
    assign in_stall = (pending >= mcv_pkg::QCNT_W'(mcv_pkg::QDEPTH));
    assign accept   = in_valid && !in_stall;

    // both line stores share one word: upper half is two rows back, lower half one row back
    mcv_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({line_mid, s1_px_reg}),
        .re    (accept),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    // the ram returns old data when the previous pixel writes the same column
    assign line     = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign line_top = line[LW-1:mcv_pkg::PIX_W];
    assign line_mid = line[mcv_pkg::PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                fwd_hit_reg   <= s1_valid_reg && (cur_col == s1_col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= in_data.pixel;
            s1_col_reg   <= cur_col;
            s1_prod_reg  <= cur_prod;
            s1_crow_reg  <= cur_row - mcv_pkg::row_t'(1);
            s1_ccol_reg  <= mcv_pkg::col_t'(cur_col_m1);
            s1_last_reg  <= cur_last;
            fwd_data_reg <= {line_mid, s1_px_reg};
        end
    end

    // two previous columns of the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= line_top;
            win_reg[4] <= line_mid;
            win_reg[5] <= s1_px_reg;
        end
    end

    assign push = s1_valid_reg && s1_prod_reg;

    always_comb
    begin
        push_data.win[0]     = win_reg[0];
        push_data.win[1]     = win_reg[3];
        push_data.win[2]     = line_top;
        push_data.win[3]     = win_reg[1];
        push_data.win[4]     = win_reg[4];
        push_data.win[5]     = line_mid;
        push_data.win[6]     = win_reg[2];
        push_data.win[7]     = win_reg[5];
        push_data.win[8]     = s1_px_reg;
        push_data.centre_row = s1_crow_reg;
        push_data.centre_col = s1_ccol_reg;
        push_data.frame_last = s1_last_reg;
    end

endmodule

`default_nettype wire

[rtl/mcv_queue.sv]
// short fifo of complete windows between the front end and the arithmetic back end
// depends on mcv_pkg
`default_nettype none

module mcv_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire mcv_pkg::task_t             push_data,
    input  wire logic                       pop,
    output logic                            head_valid,
    output mcv_pkg::task_t                  head,
    output logic [mcv_pkg::QCNT_W-1:0]      count
);

    mcv_pkg::task_t                 mem_reg [mcv_pkg::QDEPTH];
    logic [mcv_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [mcv_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [mcv_pkg::QCNT_W-1:0]     count_reg;
    logic                           do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + mcv_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + mcv_pkg::QPTR_W'(1);
            end
            count_reg <= count_reg + mcv_pkg::QCNT_W'(push) - mcv_pkg::QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/mcv_back.sv]
// back end: weighted sum, division by the mask divisor, clamp and output register
// depends on mcv_pkg
`default_nettype none

module mcv_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mcv_pkg::cfg_t         cfg,
    input  wire logic                  head_valid,
    input  wire mcv_pkg::task_t        head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output mcv_pkg::out_item_t         out_data
);

    localparam int PROD_W = mcv_pkg::RECIP_W + 12;

    logic                   adv;
    mcv_pkg::sum_t          prod [9];
    mcv_pkg::sum_t          row_sum [3];

    // stage 1: row sums
    logic                   b1_valid_reg;
    mcv_pkg::sum_t          b1_row_reg [3];
    mcv_pkg::row_t          b1_row_pos_reg;
    mcv_pkg::col_t          b1_col_pos_reg;
    logic                   b1_last_reg;

    // stage 2: total
    logic                   b2_valid_reg;
    mcv_pkg::sum_t          b2_sum_reg;
    logic                   b2_lowpass_reg;
    mcv_pkg::recip_t        b2_recip_reg;
    mcv_pkg::row_t          b2_row_pos_reg;
    mcv_pkg::col_t          b2_col_pos_reg;
    logic                   b2_last_reg;

    // stage 3: quotient
    logic [PROD_W-1:0]      quot_prod;
    mcv_pkg::sum_t          quot;
    logic                   b3_valid_reg;
    mcv_pkg::sum_t          b3_quot_reg;
    mcv_pkg::row_t          b3_row_pos_reg;
    mcv_pkg::col_t          b3_col_pos_reg;
    logic                   b3_last_reg;

    mcv_pkg::sum_t          clamp_max;
    mcv_pkg::pix_t          clamped;
    logic                   out_valid_reg;
    mcv_pkg::out_item_t     out_data_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign pop = adv && head_valid;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod[k] = mcv_pkg::sum_t'($signed({1'b0, head.win[k]})) *
                      mcv_pkg::sum_t'(mcv_pkg::MASK_COEF[cfg.mask_select][k]);
        end
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = prod[3*r] + prod[3*r+1] + prod[3*r+2];
        end
    end

    // lowpass sums are never negative and stay below 4096
    assign quot_prod = PROD_W'(b2_sum_reg[11:0]) * PROD_W'(b2_recip_reg);
    assign quot      = b2_lowpass_reg ?
                       mcv_pkg::sum_t'(quot_prod[PROD_W-1:mcv_pkg::RECIP_SHIFT]) : b2_sum_reg;

    always_comb
    begin
        clamp_max = cfg.four_bit_pixels ? mcv_pkg::CLAMP_MAX_4 : mcv_pkg::CLAMP_MAX_8;
        if (b3_quot_reg < 0)
        begin
            clamped = '0;
        end
        else if (b3_quot_reg > clamp_max)
        begin
            clamped = mcv_pkg::pix_t'(clamp_max);
        end
        else
        begin
            clamped = mcv_pkg::pix_t'(b3_quot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= head_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                b1_row_reg[r] <= row_sum[r];
            end
            b1_row_pos_reg <= head.centre_row;
            b1_col_pos_reg <= head.centre_col;
            b1_last_reg    <= head.frame_last;

            b2_sum_reg     <= b1_row_reg[0] + b1_row_reg[1] + b1_row_reg[2];
            b2_lowpass_reg <= mcv_pkg::MASK_LOWPASS[cfg.mask_select];
            b2_recip_reg   <= mcv_pkg::MASK_RECIP[cfg.mask_select];
            b2_row_pos_reg <= b1_row_pos_reg;
            b2_col_pos_reg <= b1_col_pos_reg;
            b2_last_reg    <= b1_last_reg;

            b3_quot_reg    <= quot;
            b3_row_pos_reg <= b2_row_pos_reg;
            b3_col_pos_reg <= b2_col_pos_reg;
            b3_last_reg    <= b2_last_reg;

            out_data_reg.filtered_value <= clamped;
            out_data_reg.centre_row     <= b3_row_pos_reg;
            out_data_reg.centre_col     <= b3_col_pos_reg;
            out_data_reg.frame_last     <= b3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/mask_convolution_3x3_unit.sv]
// top level of the 3x3 mask convolution unit: configuration registers and the
// front end, window queue and arithmetic back end; depends on mcv_pkg and all mcv_* modules
//
// usage
//   input channel: in_valid / in_stall / in_data carries one pixel per request in raster
//     order; frame_start marks row 0, column 0. the block drives in_stall.
//   output channel: out_valid / out_stall / out_data carries one request per interior
//     pixel (window centre, clamped filter value, frame_last on the last one).
//   configuration: cfg_write with cfg_index and cfg_data writes one register in a cycle;
//     the user must write only while no pixel is in flight; the block does not enforce it.
// timing
//   one pixel per clock sustained while in_stall stays low; the line store is one dual-port
//   ram read at acceptance and written back the next cycle, so the front holds each pixel
//   only in its s1 stage registers. a result passes the front stage, the queue, three
//   arithmetic stages and the output register in order; out_stall holds it in the back end.
//   border pixels enter but produce no result.
// reset
//   rst_n clears position counters, window, queue and pipeline valids, and loads the
//   register defaults (mask 0, 8-bit clamp, 512 x 512). the line ram is not cleared.
// stalls
//   out_stall freezes the back end while a result is held; the front keeps taking
//   pixels until the 4-entry queue is committed, then raises in_stall.
`default_nettype none

module mask_convolution_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel requests
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire mcv_pkg::in_item_t                 in_data,
    // result requests
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output mcv_pkg::out_item_t                     out_data,
    // configuration writes
    input  wire logic                              cfg_write,
    input  wire logic [mcv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mcv_pkg::cfg_t                cfg_reg;
    logic                         push;
    mcv_pkg::task_t               push_data;
    logic                         pop;
    logic                         head_valid;
    mcv_pkg::task_t               head;
    logic [mcv_pkg::QCNT_W-1:0]   q_count;

    // register file, to be written only while idle; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_select     <= '0;
            cfg_reg.four_bit_pixels <= 1'b0;
            cfg_reg.image_width     <= mcv_pkg::IMAGE_WIDTH_RESET;
            cfg_reg.image_height    <= mcv_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mcv_pkg::REG_MASK_SELECT:
                begin
                    cfg_reg.mask_select <= cfg_data[mcv_pkg::SEL_W-1:0];
                end
                mcv_pkg::REG_FOUR_BIT_PIXELS:
                begin
                    cfg_reg.four_bit_pixels <= cfg_data[0];
                end
                mcv_pkg::REG_IMAGE_WIDTH:
                begin
                    cfg_reg.image_width <= cfg_data[mcv_pkg::WID_W-1:0];
                end
                mcv_pkg::REG_IMAGE_HEIGHT:
                begin
                    cfg_reg.image_height <= cfg_data[mcv_pkg::HGT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // position tracking, line ram and window
    mcv_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    // decouples the front from back-end stalls
    mcv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    // multiply-accumulate, divide, clamp
    mcv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

[rtl/mcv_checker.sv]
// port-level checks for the 3x3 mask convolution unit, bound to the top level
// depends on mcv_pkg and mask_convolution_3x3_unit
`default_nettype none

module mcv_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire mcv_pkg::out_item_t  out_data
);

    // a stalled result request stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // results are only for interior pixels, so the centre row is never the top row
    a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.centre_row != mcv_pkg::row_t'(0)))
        else $error("result for a top border pixel");

    // nothing leaves the pipeline right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result request right after reset");

endmodule

bind mask_convolution_3x3_unit mcv_checker u_mcv_checker (.*);

`default_nettype wire

[tb/mask_convolution_3x3_unit_test.sv]
// self-checking testbench for the 3x3 mask convolution unit: random bursts of pixel
// requests against a stalling receiver, each result checked against a local filter model
// depends on mcv_pkg and mask_convolution_3x3_unit
`timescale 1ns / 1ps

module mask_convolution_3x3_unit_test;

    import mcv_pkg::*;

    // line depth of the block (its default MAX_WIDTH) and the tallest frame it takes
    localparam int LINE_DEPTH    = 1024;
    localparam int ROW_LIMIT     = 4096;
    localparam int RANDOM_ITEMS  = 1650;
    // border pixels leave nothing behind
    localparam int DRAIN_CYCLES  = 12;
    localparam int MAX_PRINTED   = 40;
    localparam int TIMEOUT_NS    = 4_000_000;

    // mask selector codes as the block decodes them
    typedef enum logic [2:0] {
        LOWPASS_6,
        LOWPASS_9,
        LOWPASS_10,
        LOWPASS_16,
        HIGHPASS_1,
        HIGHPASS_2,
        HIGHPASS_3,
        LOWPASS_6_ALIAS
    } mask_code_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // pixel requests waiting for the driver, and results still owed by the block
    in_item_t  pixel_queue [$];
    out_item_t expected_filter_out [$];
    int unsigned mismatch_count = 0;

    // filter model: register copies, line memories, window history and raster position
    mask_code_e        mask_sel   = LOWPASS_6;
    logic              four_bit   = 1'b0;
    logic [WID_W-1:0]  img_width  = IMAGE_WIDTH_RESET;
    logic [HGT_W-1:0]  img_height = IMAGE_HEIGHT_RESET;
    pix_t              row_prev  [LINE_DEPTH];
    pix_t              row_prev2 [LINE_DEPTH];
    pix_t              win_hist  [6];
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;

    // traffic shaping state
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned flow_left  = 0;

    mask_convolution_3x3_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // geometry as the block sees it: width saturates to 3..1024, height to 3..4096
    function automatic int unsigned clamp_width(input logic [WID_W-1:0] value);
        if (value < 3)
            return 3;
        if (value > LINE_DEPTH)
            return LINE_DEPTH;
        return value;
    endfunction

    function automatic int unsigned clamp_height(input logic [HGT_W-1:0] value);
        if (value < 3)
            return 3;
        if (value > ROW_LIMIT)
            return ROW_LIMIT;
        return value;
    endfunction

    // every mask is symmetric: one weight for corners, one for sides, one for the centre
    function automatic void kernel_weights(input mask_code_e code, output int corner,
                                           output int side, output int centre,
                                           output int divisor);
        case (code)
            LOWPASS_9:  begin corner = 1;  side = 1;  centre = 1; divisor = 9;  end
            LOWPASS_10: begin corner = 1;  side = 1;  centre = 2; divisor = 10; end
            LOWPASS_16: begin corner = 1;  side = 2;  centre = 4; divisor = 16; end
            HIGHPASS_1: begin corner = 0;  side = -1; centre = 5; divisor = 1;  end
            HIGHPASS_2: begin corner = -1; side = -1; centre = 9; divisor = 1;  end
            HIGHPASS_3: begin corner = 1;  side = -2; centre = 5; divisor = 1;  end
            // lowpass 6 and the spare code that aliases it
            default:    begin corner = 0;  side = 1;  centre = 2; divisor = 6;  end
        endcase
    endfunction

    // advance the model by one accepted pixel; interior pixels owe one result
    task automatic filter_pixel(input in_item_t item);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pix_t        top;
        pix_t        mid;
        int          taps [9];
        int          corner;
        int          side;
        int          centre;
        int          divisor;
        int          wt;
        int          acc;
        int          ceiling;
        int          k;
        out_item_t   res;
        w = clamp_width(img_width);
        h = clamp_height(img_height);
        // frame start wins; otherwise a shrunken geometry forces a new row or frame
        if (item.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
                row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        top = row_prev2[c];
        mid = row_prev[c];
        row_prev2[c] = mid;
        row_prev[c]  = item.pixel;
        if (r >= 2 && c >= 2)
        begin
            kernel_weights(mask_sel, corner, side, centre, divisor);
            taps[0] = win_hist[0]; taps[1] = win_hist[3]; taps[2] = top;
            taps[3] = win_hist[1]; taps[4] = win_hist[4]; taps[5] = mid;
            taps[6] = win_hist[2]; taps[7] = win_hist[5]; taps[8] = item.pixel;
            acc = 0;
            for (k = 0; k < 9; k++)
            begin
                if (k == 4)
                    wt = centre;
                else if (k % 2 == 0)
                    wt = corner;
                else
                    wt = side;
                acc += taps[k] * wt;
            end
            // integer division truncates toward zero, then clamp
            acc = acc / divisor;
            ceiling = four_bit ? 16 : 255;
            if (acc < 0)
                acc = 0;
            if (acc > ceiling)
                acc = ceiling;
            res.filtered_value = pix_t'(acc);
            res.centre_row     = row_t'(r - 1);
            res.centre_col     = col_t'(c - 1);
            res.frame_last     = (r == h - 1) && (c == w - 1);
            expected_filter_out.push_back(res);
        end
        win_hist[0] = win_hist[3];
        win_hist[1] = win_hist[4];
        win_hist[2] = win_hist[5];
        win_hist[3] = top;
        win_hist[4] = mid;
        win_hist[5] = item.pixel;
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_filter_out.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result at row %0d col %0d",
                                    got.centre_row, got.centre_col));
            return;
        end
        want = expected_filter_out.pop_front();
        if (got.filtered_value !== want.filtered_value)
            flag_mismatch($sformatf("filtered_value at row %0d col %0d: got %0d, want %0d",
                                    want.centre_row, want.centre_col,
                                    got.filtered_value, want.filtered_value));
        if (got.centre_row !== want.centre_row)
            flag_mismatch($sformatf("centre_row: got %0d, want %0d",
                                    got.centre_row, want.centre_row));
        if (got.centre_col !== want.centre_col)
            flag_mismatch($sformatf("centre_col at row %0d: got %0d, want %0d",
                                    want.centre_row, got.centre_col, want.centre_col));
        if (got.frame_last !== want.frame_last)
            flag_mismatch($sformatf("frame_last at row %0d col %0d: got %b, want %b",
                                    want.centre_row, want.centre_col,
                                    got.frame_last, want.frame_last));
    endtask

    // pixel driver: bursts of random length with random gaps, some long unbroken runs;
    // a request stays put until the block takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pixel_queue.pop_front();
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls between free-flowing stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
            flow_left  = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_stall  <= 1'b1;
        end
        else
        begin
            flow_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 8);
            out_stall <= 1'b0;
        end
    end

    // monitor: check the result request first, then predict from the pixel request,
    // so a result can never be matched against an expectation from the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
                filter_pixel(in_data);
        end
    end

    // one register write; spare data bits carry noise the block must ignore
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        case (idx)
            REG_MASK_SELECT:
            begin
                word[SEL_W-1:0] = value[SEL_W-1:0];
                mask_sel = mask_code_e'(word[SEL_W-1:0]);
            end
            REG_FOUR_BIT_PIXELS:
            begin
                word[0]  = value[0];
                four_bit = word[0];
            end
            REG_IMAGE_WIDTH:
            begin
                word[WID_W-1:0] = value[WID_W-1:0];
                img_width = word[WID_W-1:0];
            end
            REG_IMAGE_HEIGHT:
            begin
                word       = value;
                img_height = word;
            end
        endcase
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
    endtask

    task automatic configure(input mask_code_e code, input logic four,
                             input logic [WID_W-1:0] width_val,
                             input logic [HGT_W-1:0] height_val);
        write_register(REG_MASK_SELECT, CFG_DATA_W'(code));
        write_register(REG_FOUR_BIT_PIXELS, CFG_DATA_W'(four));
        write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(width_val));
        write_register(REG_IMAGE_HEIGHT, height_val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait until every request is taken and every result is back, then let the
    // pipeline empty of border pixels that owe nothing
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || in_valid || expected_filter_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_pixel(input pix_t value, input logic restart);
        in_item_t item;
        item.pixel       = value;
        item.frame_start = restart;
        pixel_queue.push_back(item);
    endtask

    // mostly full-range noise, with extremes for clamping and small values for 4-bit mode
    function automatic pix_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return pix_t'($urandom_range(0, 15));
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // a run of pixels; noise_rate nonzero scatters stray frame starts through it
    task automatic queue_stream(input int unsigned count, input logic restart,
                                input int unsigned noise_rate);
        int unsigned k;
        logic        fs;
        for (k = 0; k < count; k++)
        begin
            if (k == 0)
                fs = restart;
            else
                fs = (noise_rate != 0) && ($urandom_range(1, noise_rate) == 1);
            queue_pixel(random_pixel(), fs);
        end
    endtask

    // one random setting followed by a stream, mostly small frames
    task automatic random_phase(output int unsigned count);
        logic [WID_W-1:0] width_val;
        logic [HGT_W-1:0] height_val;
        logic             restart;
        case ($urandom_range(0, 9))
            0:       width_val = WID_W'($urandom_range(0, 2));
            1:       width_val = WID_W'($urandom_range(13, 64));
            default: width_val = WID_W'($urandom_range(3, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       height_val = HGT_W'($urandom_range(0, 2));
            1:       height_val = HGT_W'($urandom_range(9, 20));
            default: height_val = HGT_W'($urandom_range(3, 8));
        endcase
        // carrying on mid-frame covers shrunken geometry and the end-of-frame wrap;
        // a wider row mid-frame would read line memory that was never filled, so
        // widening always starts a fresh frame
        restart = ($urandom_range(0, 3) != 0);
        if (clamp_width(width_val) > clamp_width(img_width) && (col_pos != 0 || row_pos != 0))
            restart = 1'b1;
        configure(mask_code_e'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  width_val, height_val);
        count = $urandom_range(8, 90);
        queue_stream(count, restart, $urandom_range(0, 1) ? 60 : 0);
        wait_idle();
    endtask

    initial
    begin : stimulus
        int unsigned k;
        int unsigned random_items;
        for (k = 0; k < LINE_DEPTH; k++)
        begin
            row_prev[k]  = '0;
            row_prev2[k] = '0;
        end
        for (k = 0; k < 6; k++)
            win_hist[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flat white frame through the spare selector, width and height below range
        configure(LOWPASS_6_ALIAS, 1'b0, 11'd0, 13'd0);
        for (k = 0; k < 9; k++)
            queue_pixel(8'hFF, k == 0);
        wait_idle();

        // lone bright centre under the sharpest highpass, clamped at the 4-bit ceiling
        configure(HIGHPASS_2, 1'b1, 11'd3, 13'd3);
        for (k = 0; k < 9; k++)
            queue_pixel((k == 4) ? 8'hFF : 8'h00, k == 0);
        wait_idle();

        // dark centre in a bright ring goes negative; frame follows by wrap alone
        configure(HIGHPASS_1, 1'b0, 11'd2, 13'd1);
        for (k = 0; k < 9; k++)
            queue_pixel((k == 4) ? 8'h00 : 8'hFF, 1'b0);
        wait_idle();

        // widest frame: width register at its top, saturating to the line depth
        configure(mask_code_e'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  11'h7FF, 13'd3);
        queue_stream(3 * LINE_DEPTH, 1'b1, 0);
        wait_idle();

        // tallest frame at minimum width, plus a row past its wrap
        configure(mask_code_e'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  11'd1, 13'h1FFF);
        queue_stream(3 * ROW_LIMIT + 3, 1'b1, 0);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            random_phase(k);
            random_items += k;
        end

        if (mismatch_count == 0)
            $display("mask_convolution_3x3_unit regression: pass");
        else
            $display("mask_convolution_3x3_unit regression: fail");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("mask_convolution_3x3_unit regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/mcv_pkg.sv
rtl/mcv_ram.sv
rtl/mcv_front.sv
rtl/mcv_queue.sv
rtl/mcv_back.sv
rtl/mask_convolution_3x3_unit.sv
rtl/mcv_checker.sv
tb/mask_convolution_3x3_unit_test.sv
